/* hdl/mlp_pkg.sv */
`default_nettype none
package mlp_pkg;

    localparam int ACC_W = 44;
    localparam int PRM_W = 16;
    localparam int ACT_W = 16;
    localparam int PRD_W = PRM_W + ACT_W + 1;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 2'd2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic signed [ACC_W-1:0] ACC_HI = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_LO = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] SIG_RANGE = 44'sd1073741824;
    localparam logic [63:0] EXP_STEP_Q30 = 64'd1040706261;

    typedef logic [255:0][15:0] t_lut;

    typedef struct packed {
        logic load;
        logic act_take;
        logic rd_hid;
        logic rd_out;
        logic rd_ob;
        logic first;
        logic seed;
        logic emit;
    } t_cmd;

    // sigmoid(-8 + (2i+1)/32) in Q1.15, built at elaboration
    function automatic t_lut build_lut();
        t_lut t;
        logic [63:0] p;
        logic [63:0] d;
        logic [63:0] n;
        logic [63:0] q;
        logic [63:0] r;
        int step;
        int k;
        p = 64'd1 << 30;
        step = 0;
        t = '0;
        for (int i = 128; i < 256; i++) begin
            k = 2 * i - 255;
            for (int s = 0; s < 256; s++) begin
                if (step < k) begin
                    p = (p * EXP_STEP_Q30 + (64'd1 << 29)) >> 30;
                    step++;
                end
            end
            d = (64'd1 << 30) + p;
            n = (64'd1 << 45) + (d >> 1);
            q = '0;
            r = '0;
            for (int b = 46; b >= 0; b--) begin
                r = {r[62:0], n[b]};
                if (r >= d) begin
                    r = r - d;
                    q[b] = 1'b1;
                end
            end
            t[i] = q[15:0];
        end
        for (int i = 0; i < 128; i++) begin
            t[i] = 16'd32768 - t[255-i];
        end
        return t;
    endfunction

    localparam t_lut SIG_LUT = build_lut();

    function automatic logic [15:0] sig_lookup(input logic signed [ACC_W-1:0] x);
        logic [ACC_W-1:0] sh;
        logic [7:0] idx;
        sh = x + SIG_RANGE;
        if (x < -SIG_RANGE) begin
            idx = 8'd0;
        end else if (x >= SIG_RANGE) begin
            idx = 8'd255;
        end else begin
            idx = sh[30:23];
        end
        return SIG_LUT[idx];
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [PRD_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {{(ACC_W+1-PRD_W){b[PRD_W-1]}}, b};
        if (s > $signed({ACC_HI[ACC_W-1], ACC_HI})) begin
            return ACC_HI;
        end else if (s < $signed({ACC_LO[ACC_W-1], ACC_LO})) begin
            return ACC_LO;
        end
        return s[ACC_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* hdl/mlp_dp.sv */
`default_nettype none
module mlp_dp #(
    parameter int INPUT_MAX = 1024,
    parameter int HIDDEN_MAX = 64,
    parameter int OUTPUT_MAX = 16,
    parameter int IAW = 10,
    parameter int HAW = 6,
    parameter int OAW = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mlp_pkg::t_cmd               i_cmd,
    input  wire logic [HAW-1:0]              i_h,
    input  wire logic [OAW-1:0]              i_o,
    input  wire logic [IAW-1:0]              i_src,
    input  wire logic                        i_layer_select,
    input  wire logic                        i_is_bias,
    input  wire logic [15:0]                 i_param_index,
    input  wire logic signed [15:0]          i_param_value,
    input  wire logic [15:0]                 i_activation,
    output logic                             o_busy,
    output logic [15:0]                      o_value
);

    localparam int HW_DEPTH = HIDDEN_MAX * INPUT_MAX;
    localparam int OW_DEPTH = OUTPUT_MAX * HIDDEN_MAX;
    localparam int HW_AW = (HW_DEPTH > 1) ? $clog2(HW_DEPTH) : 1;
    localparam int OW_AW = (OW_DEPTH > 1) ? $clog2(OW_DEPTH) : 1;
    localparam int ACC_W = mlp_pkg::ACC_W;
    localparam int PRD_W = mlp_pkg::PRD_W;

    logic signed [15:0] hw_mem [HW_DEPTH];
    logic signed [15:0] ow_mem [OW_DEPTH];
    logic signed [15:0] hb_mem [HIDDEN_MAX];
    logic signed [15:0] ob_mem [OUTPUT_MAX];
    logic signed [ACC_W-1:0] sum_mem [HIDDEN_MAX];

    logic [HIDDEN_MAX-1:0] r_sum_vld;
    logic r_s1_v, r_s2_v, r_t1_v, r_t2_v, r_t3_v;

    logic [15:0] r_act;
    logic signed [15:0] r_hw_q, r_hb_q, r_ow_q, r_ob_q, r_ow2;
    logic signed [ACC_W-1:0] r_sum_q, r_base, r_acc;
    logic r_sv_q;
    logic [HAW-1:0] r_s1_h, r_s2_h;
    logic signed [PRD_W-1:0] r_prod, r_oprod;
    logic [16:0] r_hact;
    logic [15:0] r_res;

    logic [31:0] hw_addr_full, ow_addr_full;
    logic [HW_AW-1:0] hw_addr;
    logic [OW_AW-1:0] ow_addr;
    logic [HW_AW-1:0] ld_hw_addr;
    logic [OW_AW-1:0] ld_ow_addr;
    logic signed [ACC_W-1:0] sum_in;
    logic signed [ACC_W-1:0] n_sum;

    assign hw_addr_full = 32'(i_h) * 32'(INPUT_MAX) + 32'(i_src);
    assign ow_addr_full = 32'(i_o) * 32'(HIDDEN_MAX) + 32'(i_h);
    assign hw_addr = hw_addr_full[HW_AW-1:0];
    assign ow_addr = ow_addr_full[OW_AW-1:0];
    assign ld_hw_addr = HW_AW'(i_param_index);
    assign ld_ow_addr = OW_AW'(i_param_index);
    assign sum_in = r_sv_q ? r_sum_q : '0;
    assign n_sum = mlp_pkg::sat_add(r_base, r_prod);

    // parameter loads, store reads and running-sum writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (!i_layer_select && i_is_bias) begin
                if (32'(i_param_index) < 32'(HIDDEN_MAX)) begin
                    hb_mem[HAW'(i_param_index)] <= i_param_value;
                end
            end else if (!i_layer_select) begin
                if (32'(i_param_index) < 32'(HW_DEPTH)) begin
                    hw_mem[ld_hw_addr] <= i_param_value;
                end
            end else if (i_is_bias) begin
                if (32'(i_param_index) < 32'(OUTPUT_MAX)) begin
                    ob_mem[OAW'(i_param_index)] <= i_param_value;
                end
            end else begin
                if (32'(i_param_index) < 32'(OW_DEPTH)) begin
                    ow_mem[ld_ow_addr] <= i_param_value;
                end
            end
        end
        if (i_cmd.rd_hid) begin
            r_hw_q <= hw_mem[hw_addr];
            r_hb_q <= hb_mem[i_h];
        end
        if (i_cmd.rd_out) begin
            r_ow_q <= ow_mem[ow_addr];
        end
        if (i_cmd.rd_hid || i_cmd.rd_out) begin
            r_sum_q <= sum_mem[i_h];
            r_sv_q <= r_sum_vld[i_h];
        end
        if (i_cmd.rd_ob) begin
            r_ob_q <= ob_mem[i_o];
        end
        if (r_s2_v) begin
            sum_mem[r_s2_h] <= n_sum;
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.act_take) begin
            r_act <= i_activation;
        end
        r_s1_h <= i_h;
        r_s2_h <= r_s1_h;
        r_prod <= r_hw_q * $signed({1'b0, r_act});
        r_base <= i_cmd.first ? {{(ACC_W-31){r_hb_q[15]}}, r_hb_q, 15'b0} : sum_in;
        r_hact <= {1'b0, mlp_pkg::sig_lookup(sum_in)};
        r_ow2 <= r_ow_q;
        r_oprod <= r_ow2 * $signed(r_hact);
        if (i_cmd.seed) begin
            r_acc <= {{(ACC_W-31){r_ob_q[15]}}, r_ob_q, 15'b0};
        end else if (r_t3_v) begin
            r_acc <= mlp_pkg::sat_add(r_acc, r_oprod);
        end
        if (i_cmd.emit) begin
            r_res <= mlp_pkg::sig_lookup(r_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld <= '0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_t1_v <= 1'b0;
            r_t2_v <= 1'b0;
            r_t3_v <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.rd_hid;
            r_s2_v <= r_s1_v;
            r_t1_v <= i_cmd.rd_out;
            r_t2_v <= r_t1_v;
            r_t3_v <= r_t2_v;
            if (r_s2_v) begin
                r_sum_vld[r_s2_h] <= 1'b1;
            end
        end
    end

    assign o_busy = r_s1_v | r_s2_v | r_t1_v | r_t2_v | r_t3_v;
    assign o_value = r_res;

endmodule
`default_nettype wire

/* hdl/mlp_ctrl.sv */
`default_nettype none
module mlp_ctrl #(
    parameter int INPUT_MAX = 1024,
    parameter int HIDDEN_MAX = 64,
    parameter int OUTPUT_MAX = 16,
    parameter int IAW = 10,
    parameter int HAW = 6,
    parameter int OAW = 4,
    parameter int NIW = 11,
    parameter int NHW = 7,
    parameter int NOW = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [NIW-1:0]    i_n_in,
    input  wire logic [NHW-1:0]    i_n_hid,
    input  wire logic [NOW-1:0]    i_n_out,
    input  wire logic              i_in_valid,
    input  wire logic              i_operation,
    output logic                   o_in_ready,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [3:0]             o_neuron_index,
    output logic                   o_last,
    input  wire logic              i_busy,
    output mlp_pkg::t_cmd          o_cmd,
    output logic [HAW-1:0]         o_h,
    output logic [OAW-1:0]         o_o,
    output logic [IAW-1:0]         o_src
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HID   = 3'd1;
    localparam logic [2:0] S_HDRN  = 3'd2;
    localparam logic [2:0] S_OBIAS = 3'd3;
    localparam logic [2:0] S_OSEED = 3'd4;
    localparam logic [2:0] S_ODOT  = 3'd5;
    localparam logic [2:0] S_ODRN  = 3'd6;
    localparam logic [2:0] S_OWAIT = 3'd7;

    logic [2:0] r_state, n_state;
    logic [NIW-1:0] r_ecnt, n_ecnt;
    logic [IAW-1:0] r_src, n_src;
    logic [HAW-1:0] r_h, n_h;
    logic [OAW-1:0] r_o, n_o;
    logic r_first, n_first;
    logic r_out_v, n_out_v;
    logic [3:0] r_oidx, n_oidx;
    logic r_olast, n_olast;
    logic h_end, o_end;

    assign h_end = (NHW'(r_h) + NHW'(1)) == i_n_hid;
    assign o_end = (NOW'(r_o) + NOW'(1)) == i_n_out;

    always_comb begin
        n_state = r_state;
        n_ecnt = r_ecnt;
        n_src = r_src;
        n_h = r_h;
        n_o = r_o;
        n_first = r_first;
        n_out_v = r_out_v;
        n_oidx = r_oidx;
        n_olast = r_olast;
        o_cmd = '0;
        o_cmd.first = r_first;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_operation == mlp_pkg::OP_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.act_take = 1'b1;
                        n_first = (r_ecnt == '0);
                        n_src = IAW'(r_ecnt);
                        n_ecnt = r_ecnt + NIW'(1);
                        n_h = '0;
                        n_state = S_HID;
                    end
                end
            end
            S_HID: begin
                o_cmd.rd_hid = 1'b1;
                if (h_end) begin
                    n_h = '0;
                    n_state = S_HDRN;
                end else begin
                    n_h = r_h + HAW'(1);
                end
            end
            S_HDRN: begin
                if (!i_busy) begin
                    if (r_ecnt >= i_n_in) begin
                        n_ecnt = '0;
                        n_o = '0;
                        n_state = S_OBIAS;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_OBIAS: begin
                o_cmd.rd_ob = 1'b1;
                n_state = S_OSEED;
            end
            S_OSEED: begin
                o_cmd.seed = 1'b1;
                n_h = '0;
                n_state = S_ODOT;
            end
            S_ODOT: begin
                o_cmd.rd_out = 1'b1;
                if (h_end) begin
                    n_h = '0;
                    n_state = S_ODRN;
                end else begin
                    n_h = r_h + HAW'(1);
                end
            end
            S_ODRN: begin
                if (!i_busy) begin
                    o_cmd.emit = 1'b1;
                    n_out_v = 1'b1;
                    n_oidx = 4'(r_o);
                    n_olast = o_end;
                    n_state = S_OWAIT;
                end
            end
            S_OWAIT: begin
                if (i_out_ready) begin
                    n_out_v = 1'b0;
                    if (r_olast) begin
                        n_state = S_IDLE;
                    end else begin
                        n_o = r_o + OAW'(1);
                        n_state = S_OBIAS;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ecnt <= '0;
            r_out_v <= 1'b0;
            r_h <= '0;
            r_o <= '0;
        end else begin
            r_state <= n_state;
            r_ecnt <= n_ecnt;
            r_out_v <= n_out_v;
            r_h <= n_h;
            r_o <= n_o;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src <= n_src;
        r_first <= n_first;
        r_oidx <= n_oidx;
        r_olast <= n_olast;
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_v;
    assign o_neuron_index = r_oidx;
    assign o_last = r_olast;
    assign o_h = r_h;
    assign o_o = r_o;
    assign o_src = r_src;

    a_out_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> r_state == S_OWAIT)
        else $error("result valid outside wait state");

    a_emit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !i_busy)
        else $error("result taken before pipeline drained");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && i_out_ready && r_olast) |=> r_state == S_IDLE)
        else $error("no return to idle after last result");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HID || r_state == S_ODOT) |-> !o_in_ready)
        else $error("request accepted during a pass");

endmodule
`default_nettype wire

/* hdl/mlp_two_layer_inference.sv */
// Two-layer perceptron inference with sigmoid activations.
// Input channel (i_in_valid/o_in_ready): a load request (operation 0)
// writes one weight or bias word into its store and gives no result. A
// sample request (operation 1) carries one activation; the block sweeps
// every hidden neuron in use through one multiply-accumulate unit, one
// neuron per cycle. When input_count activations have arrived, each
// output neuron goes through read bias, seed, sweep and drain before its
// result appears on o_out_valid; the last is flagged by o_last.
// The output register holds a result until i_out_ready; while the receiver
// stalls, no new request is taken. Requests are accepted one at a time.
// Configuration (i_cfg_we/i_cfg_idx/i_cfg_data) writes input_count,
// hidden_count and output_count; zero counts act as one, larger ones clip
// to the build limits. Reset clears the sample counter and running sums
// and restores counts 784/64/10; weight and bias stores hold garbage until
// loaded.
`default_nettype none
module mlp_two_layer_inference #(
    parameter int INPUT_MAX = 1024,
    parameter int HIDDEN_MAX = 64,
    parameter int OUTPUT_MAX = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [mlp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [mlp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_operation,
    input  wire logic                               i_layer_select,
    input  wire logic                               i_is_bias,
    input  wire logic [15:0]                        i_param_index,
    input  wire logic signed [15:0]                 i_param_value,
    input  wire logic [15:0]                        i_activation,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [3:0]                              o_neuron_index,
    output logic [15:0]                             o_neuron_value,
    output logic                                    o_last
);

    localparam int IAW = (INPUT_MAX > 1) ? $clog2(INPUT_MAX) : 1;
    localparam int HAW = (HIDDEN_MAX > 1) ? $clog2(HIDDEN_MAX) : 1;
    localparam int OAW = (OUTPUT_MAX > 1) ? $clog2(OUTPUT_MAX) : 1;
    localparam int NIW = $clog2(INPUT_MAX + 1);
    localparam int NHW = $clog2(HIDDEN_MAX + 1);
    localparam int NOW = $clog2(OUTPUT_MAX + 1);

    logic [10:0] r_input_count;
    logic [6:0] r_hidden_count;
    logic [4:0] r_output_count;
    logic [NIW-1:0] n_in;
    logic [NHW-1:0] n_hid;
    logic [NOW-1:0] n_out;

    mlp_pkg::t_cmd cmd;
    logic busy;
    logic [HAW-1:0] h;
    logic [OAW-1:0] o;
    logic [IAW-1:0] src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_count <= 11'd784;
            r_hidden_count <= 7'd64;
            r_output_count <= 5'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mlp_pkg::CFG_INPUT_COUNT: r_input_count <= i_cfg_data;
                mlp_pkg::CFG_HIDDEN_COUNT: r_hidden_count <= i_cfg_data[6:0];
                mlp_pkg::CFG_OUTPUT_COUNT: r_output_count <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_input_count == '0) begin
            n_in = NIW'(1);
        end else if (32'(r_input_count) > 32'(INPUT_MAX)) begin
            n_in = NIW'(INPUT_MAX);
        end else begin
            n_in = NIW'(r_input_count);
        end
        if (r_hidden_count == '0) begin
            n_hid = NHW'(1);
        end else if (32'(r_hidden_count) > 32'(HIDDEN_MAX)) begin
            n_hid = NHW'(HIDDEN_MAX);
        end else begin
            n_hid = NHW'(r_hidden_count);
        end
        if (r_output_count == '0) begin
            n_out = NOW'(1);
        end else if (32'(r_output_count) > 32'(OUTPUT_MAX)) begin
            n_out = NOW'(OUTPUT_MAX);
        end else begin
            n_out = NOW'(r_output_count);
        end
    end

    mlp_ctrl #(
        .INPUT_MAX(INPUT_MAX), .HIDDEN_MAX(HIDDEN_MAX), .OUTPUT_MAX(OUTPUT_MAX),
        .IAW(IAW), .HAW(HAW), .OAW(OAW), .NIW(NIW), .NHW(NHW), .NOW(NOW)
    ) u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_n_in(n_in),
        .i_n_hid(n_hid),
        .i_n_out(n_out),
        .i_in_valid(i_in_valid),
        .i_operation(i_operation),
        .o_in_ready(o_in_ready),
        .i_out_ready(i_out_ready),
        .o_out_valid(o_out_valid),
        .o_neuron_index(o_neuron_index),
        .o_last(o_last),
        .i_busy(busy),
        .o_cmd(cmd),
        .o_h(h),
        .o_o(o),
        .o_src(src)
    );

    mlp_dp #(
        .INPUT_MAX(INPUT_MAX), .HIDDEN_MAX(HIDDEN_MAX), .OUTPUT_MAX(OUTPUT_MAX),
        .IAW(IAW), .HAW(HAW), .OAW(OAW)
    ) u_dp (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd(cmd),
        .i_h(h),
        .i_o(o),
        .i_src(src),
        .i_layer_select(i_layer_select),
        .i_is_bias(i_is_bias),
        .i_param_index(i_param_index),
        .i_param_value(i_param_value),
        .i_activation(i_activation),
        .o_busy(busy),
        .o_value(o_neuron_value)
    );

endmodule
`default_nettype wire

/* tb/mlp_two_layer_inference_tb.sv */
`default_nettype none
module mlp_two_layer_inference_tb;

    localparam int N_IN_CAP = 1024;
    localparam int N_HID_CAP = 64;
    localparam int N_OUT_CAP = 16;
    localparam longint SUM_HI = 64'sd8796093022207;
    localparam longint SUM_LO = -64'sd8796093022208;
    localparam longint SIG_EDGE = 64'sd1073741824;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 120;

    typedef struct {
        logic [3:0]  idx;
        logic [15:0] value;
        logic        last;
    } t_neuron_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [mlp_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [mlp_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic                           i_operation = mlp_pkg::OP_LOAD;
    logic                           i_layer_select = 1'b0;
    logic                           i_is_bias = 1'b0;
    logic [15:0]                    i_param_index = '0;
    logic signed [15:0]             i_param_value = '0;
    logic [15:0]                    i_activation = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [3:0]                     o_neuron_index;
    logic [15:0]                    o_neuron_value;
    logic                           o_last;

    mlp_two_layer_inference i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_operation(i_operation), .i_layer_select(i_layer_select),
        .i_is_bias(i_is_bias), .i_param_index(i_param_index),
        .i_param_value(i_param_value), .i_activation(i_activation),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_neuron_index(o_neuron_index), .o_neuron_value(o_neuron_value),
        .o_last(o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic signed [15:0] hid_w [N_HID_CAP*N_IN_CAP];
    logic signed [15:0] out_w [N_OUT_CAP*N_HID_CAP];
    logic signed [15:0] hid_b [N_HID_CAP];
    logic signed [15:0] out_b [N_OUT_CAP];
    longint             hid_sum [N_HID_CAP];
    int                 act_cnt = 0;
    int unsigned        reg_inputs = 784;
    int unsigned        reg_hidden = 64;
    int unsigned        reg_outputs = 10;
    int unsigned        sig_lut [256];

    t_neuron_result     pending_results[$];
    int                 errors = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 hold_seq = 0;
    int                 hold_seen = 0;
    int                 hold_left = 0;
    longint             cycles = 0;

    function automatic void build_sig_lut();
        longint unsigned p;
        longint unsigned d;
        int              k;
        int              step;
        p = 64'd1 << 30;
        step = 0;
        for (int i = 128; i < 256; i++) begin
            k = 2 * i - 255;
            while (step < k) begin
                p = (p * 64'd1040706261 + (64'd1 << 29)) >> 30;
                step++;
            end
            d = (64'd1 << 30) + p;
            sig_lut[i] = 32'(((64'd1 << 45) + (d >> 1)) / d);
        end
        for (int i = 0; i < 128; i++) begin
            sig_lut[i] = 32768 - sig_lut[255-i];
        end
    endfunction

    function automatic int unsigned sigmoid_q15(longint x);
        if (x < -SIG_EDGE) begin
            return sig_lut[0];
        end else if (x >= SIG_EDGE) begin
            return sig_lut[255];
        end
        return sig_lut[(x + SIG_EDGE) >>> 23];
    endfunction

    function automatic longint clip_add(longint a, longint b);
        longint s;
        s = a + b;
        if (s > SUM_HI) begin
            return SUM_HI;
        end else if (s < SUM_LO) begin
            return SUM_LO;
        end
        return s;
    endfunction

    function automatic int unsigned eff_count(int unsigned v, int unsigned cap);
        if (v == 0) begin
            return 1;
        end
        return (v > cap) ? cap : v;
    endfunction

    function automatic void predict_request(logic op, logic layer, logic bias,
                                            logic [15:0] idx, logic signed [15:0] val,
                                            logic [15:0] act);
        int unsigned    n_in;
        int unsigned    n_hid;
        int unsigned    n_out;
        int             src;
        longint         base;
        longint         acc;
        longint         hid_act [N_HID_CAP];
        t_neuron_result r;
        n_in = eff_count(reg_inputs, N_IN_CAP);
        n_hid = eff_count(reg_hidden, N_HID_CAP);
        n_out = eff_count(reg_outputs, N_OUT_CAP);
        if (op == mlp_pkg::OP_LOAD) begin
            if (!layer && bias) begin
                if (idx < N_HID_CAP) hid_b[idx] = val;
            end else if (!layer) begin
                hid_w[idx] = val;
            end else if (bias) begin
                if (idx < N_OUT_CAP) out_b[idx] = val;
            end else begin
                if (idx < N_OUT_CAP * N_HID_CAP) out_w[idx] = val;
            end
            return;
        end
        src = (act_cnt < N_IN_CAP) ? act_cnt : N_IN_CAP - 1;
        for (int h = 0; h < n_hid; h++) begin
            base = (act_cnt == 0) ? longint'(hid_b[h]) * 32768 : hid_sum[h];
            hid_sum[h] = clip_add(base, longint'(hid_w[h*N_IN_CAP+src]) * longint'(act));
        end
        act_cnt++;
        if (act_cnt < n_in) return;
        act_cnt = 0;
        for (int h = 0; h < n_hid; h++) begin
            hid_act[h] = longint'(sigmoid_q15(hid_sum[h]));
        end
        for (int o = 0; o < n_out; o++) begin
            acc = longint'(out_b[o]) * 32768;
            for (int h = 0; h < n_hid; h++) begin
                acc = clip_add(acc, longint'(out_w[o*N_HID_CAP+h]) * hid_act[h]);
            end
            r.idx = o[3:0];
            r.value = 16'(sigmoid_q15(acc));
            r.last = (o + 1 == n_out);
            pending_results.push_back(r);
        end
    endfunction

    task automatic report(string msg);
        $display("mismatch @%0d: %s", cycles, msg);
        errors++;
    endtask

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= 400;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_neuron_result exp_r;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result neuron %0d", o_neuron_index));
            end else begin
                exp_r = pending_results.pop_front();
                if (o_neuron_index !== exp_r.idx)
                    report($sformatf("neuron_index %0d, want %0d", o_neuron_index, exp_r.idx));
                if (o_neuron_value !== exp_r.value)
                    report($sformatf("neuron %0d value %0d, want %0d",
                                     exp_r.idx, o_neuron_value, exp_r.value));
                if (o_last !== exp_r.last)
                    report($sformatf("neuron %0d last %b, want %b", exp_r.idx, o_last, exp_r.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("mlp_two_layer_inference_tb: errors");
            $finish;
        end
    end

    task automatic send_request(logic op, logic layer, logic bias, logic [15:0] idx,
                                logic signed [15:0] val, logic [15:0] act);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_layer_select <= layer;
        i_is_bias <= bias;
        i_param_index <= idx;
        i_param_value <= val;
        i_activation <= act;
        do @(posedge i_clk); while (!o_in_ready);
        predict_request(op, layer, bias, idx, val, act);
    endtask

    task automatic load_word(logic layer, logic bias, logic [15:0] idx,
                             logic signed [15:0] val);
        send_request(mlp_pkg::OP_LOAD, layer, bias, idx, val, 16'($urandom));
    endtask

    task automatic sample(logic [15:0] act);
        send_request(mlp_pkg::OP_SAMPLE, 1'($urandom), 1'($urandom), 16'($urandom),
                     16'($urandom), act);
    endtask

    function automatic logic [15:0] rand_act();
        return ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
    endfunction

    // all expected results out, then give a silent request time to finish
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [mlp_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[mlp_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        case (idx)
            mlp_pkg::CFG_INPUT_COUNT:  reg_inputs = val & 32'h7FF;
            mlp_pkg::CFG_HIDDEN_COUNT: reg_hidden = val & 32'h7F;
            mlp_pkg::CFG_OUTPUT_COUNT: reg_outputs = val & 32'h1F;
            default: ;
        endcase
    endtask

    task automatic set_counts(int unsigned n_in, int unsigned n_hid, int unsigned n_out);
        write_reg(mlp_pkg::CFG_INPUT_COUNT, n_in);
        write_reg(mlp_pkg::CFG_HIDDEN_COUNT, n_hid);
        write_reg(mlp_pkg::CFG_OUTPUT_COUNT, n_out);
        i_cfg_we <= 1'b0;
    endtask

    // close out a partial sample so the next count change starts clean
    task automatic finish_sample();
        while (act_cnt != 0) sample(rand_act());
        settle();
    endtask

    // every entry any later sample reads: all biases, source 0 of every
    // hidden neuron, sources 0..3 of neurons 0..3, output weights of
    // hidden 0..3 for every output and all of output 0
    task automatic test_param_load();
        for (int h = 0; h < N_HID_CAP; h++) load_word(1'b0, 1'b1, 16'(h), 16'($urandom));
        for (int o = 0; o < N_OUT_CAP; o++) load_word(1'b1, 1'b1, 16'(o), 16'($urandom));
        for (int o = 0; o < N_OUT_CAP; o++)
            for (int h = 0; h < 4; h++)
                load_word(1'b1, 1'b0, 16'(o * N_HID_CAP + h), 16'($urandom));
        for (int h = 4; h < N_HID_CAP; h++) load_word(1'b1, 1'b0, 16'(h), 16'($urandom));
        for (int h = 0; h < N_HID_CAP; h++)
            load_word(1'b0, 1'b0, 16'(h * N_IN_CAP), 16'($urandom));
        for (int h = 0; h < 4; h++)
            for (int s = 1; s < 4; s++)
                load_word(1'b0, 1'b0, 16'(h * N_IN_CAP + s), 16'($urandom));
        // out-of-range loads must leave the stores alone
        load_word(1'b0, 1'b1, 16'd64, 16'sh7FFF);
        load_word(1'b0, 1'b1, 16'hFFFF, 16'sh7FFF);
        load_word(1'b1, 1'b1, 16'd16, 16'sh8000);
        load_word(1'b1, 1'b0, 16'd1024, 16'sh8000);
        load_word(1'b1, 1'b0, 16'hFFFF, 16'sh7FFF);
        settle();
    endtask

    task automatic test_extremes();
        set_counts(1, 1, 1);
        load_word(1'b0, 1'b1, 16'd0, 16'sh7FFF);
        load_word(1'b0, 1'b0, 16'd0, 16'sh7FFF);
        load_word(1'b1, 1'b1, 16'd0, 16'sh7FFF);
        load_word(1'b1, 1'b0, 16'd0, 16'sh7FFF);
        sample(16'd0);
        sample(16'd32768);
        sample(16'hFFFF);
        load_word(1'b0, 1'b1, 16'd0, 16'sh8000);
        load_word(1'b0, 1'b0, 16'd0, 16'sh8000);
        load_word(1'b1, 1'b1, 16'd0, 16'sh8000);
        sample(16'd32768);
        sample(16'd0);
        load_word(1'b0, 1'b0, 16'd0, 16'sh0000);
        load_word(1'b0, 1'b1, 16'd0, 16'sh0000);
        sample(16'h5555);
        sample(16'hAAAA);
        settle();
    endtask

    task automatic test_count_limits();
        set_counts(0, 0, 0);
        sample(rand_act());
        settle();
        set_counts(1, 127, 1);
        repeat (2) sample(rand_act());
        settle();
        set_counts(1, 2, 31);
        repeat (2) sample(rand_act());
        settle();
    endtask

    task automatic test_midsample_change();
        set_counts(8, 2, 3);
        repeat (3) sample(rand_act());
        settle();
        set_counts(2, 4, 3);
        sample(rand_act());
        settle();
        set_counts(6, 4, 5);
        repeat (2) sample(rand_act());
        settle();
        set_counts(3, 4, 5);
        finish_sample();
    endtask

    task automatic test_backpressure();
        set_counts(1, 4, 16);
        send_idle_pct = 0;
        hold_seq++;
        repeat (20) sample(rand_act());
        settle();
    endtask

    task automatic random_phase(int n_items);
        int pick;
        set_counts($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 16));
        repeat (n_items) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                sample(rand_act());
            end else if (pick < 78) begin
                load_word(1'b0, 1'b0, 16'($urandom), 16'($urandom));
            end else if (pick < 85) begin
                load_word(1'b0, 1'b1, 16'($urandom_range(0, 63)), 16'($urandom));
            end else if (pick < 92) begin
                load_word(1'b1, 1'b0, 16'($urandom_range(0, 1023)), 16'($urandom));
            end else if (pick < 96) begin
                load_word(1'b1, 1'b1, 16'($urandom_range(0, 15)), 16'($urandom));
            end else begin
                load_word(1'b1, 1'($urandom_range(0, 1)), 16'($urandom_range(1024, 65535)),
                          16'($urandom));
            end
        end
        finish_sample();
    endtask

    task automatic test_random();
        int idle_modes [4][2];
        idle_modes = '{'{0, 0}, '{74, 0}, '{0, 74}, '{34, 34}};
        for (int m = 0; m < 4; m++) begin
            send_idle_pct = idle_modes[m][0];
            recv_stall_pct = idle_modes[m][1];
            repeat (2) random_phase(8);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(6);
    endtask

    initial begin
        build_sig_lut();
        for (int h = 0; h < N_HID_CAP; h++) hid_sum[h] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_param_load();
        test_extremes();
        test_count_limits();
        test_midsample_change();
        test_backpressure();
        test_random();
        settle();
        if (errors == 0) begin
            $display("mlp_two_layer_inference_tb: clean");
        end else begin
            $display("mlp_two_layer_inference_tb: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* mlp_two_layer_inference.f */
hdl/mlp_pkg.sv
hdl/mlp_dp.sv
hdl/mlp_ctrl.sv
hdl/mlp_two_layer_inference.sv
tb/mlp_two_layer_inference_tb.sv
